### rtl/h2r_pkg.sv
// Shared types for the HSV to RGB pixel pipeline.
// No dependencies; every rtl module of the block imports this package.
package h2r_pkg;

    // Hue sectors, each one sixth of the circle
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYA = 3'd2,
        SEC_CYA_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } h2r_sector_t;

    // After stage 1: sector plus the factors that multiply the value
    typedef struct packed {
        h2r_sector_t sector;
        logic [7:0]  v;
        logic [8:0]  a_p;   // 256 - s
        logic [16:0] a_q;   // 2^16 - s*f
        logic [16:0] a_t;   // 2^16 - s*(256-f)
    } h2r_frac_t;

    // After stage 2: value times each factor
    typedef struct packed {
        h2r_sector_t sector;
        logic [7:0]  v;
        logic [16:0] p_num;
        logic [24:0] q_num;
        logic [24:0] t_num;
    } h2r_prod_t;

    // Final pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } h2r_rgb_t;

endpackage

### rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter.
// Depends on h2r_pkg, h2r_frac, h2r_mul and h2r_out.

// Converts one 8-bit hue/saturation/brightness pixel per clock while out_stall
// is low into 8-bit red/green/blue, each the floor of 255 times the exact
// fixed-point fraction. The pipeline has three register stages (sector and
// factors, value products, scale and route). When nothing stalls, an item
// passes through the stage 1, stage 2 and stage 3 registers in turn, out_valid
// rises once it reaches the stage 3 register, and one item can enter every
// cycle. Each stage holds its item only while the next stage stalls; an empty
// stage always takes a new item, so bubbles close up and in_stall rises only
// once all three stages are full and out_stall is high.
// Zero saturation needs no special path: the general formulas give gray.
module hsv_to_rgb_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] hue,
    input  logic [7:0] saturation,
    input  logic [7:0] brightness,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);
    import h2r_pkg::*;

    // Stage to stage handshakes
    logic      s1_valid;
    logic      s1_stall;
    h2r_frac_t s1_data;
    logic      s2_valid;
    logic      s2_stall;
    h2r_prod_t s2_data;
    h2r_rgb_t  s3_data;

    // Stage 1: six-fold hue, sector, saturation factors
    h2r_frac u_frac (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .dn_valid   (s1_valid),
        .dn_stall   (s1_stall),
        .dn_data    (s1_data)
    );

    // Stage 2: brightness times each factor
    h2r_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_stall (s1_stall),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_stall (s2_stall),
        .dn_data  (s2_data)
    );

    // Stage 3: scale by 255, floor, route by sector; this is the output register
    h2r_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_stall (s2_stall),
        .up_data  (s2_data),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .dn_data  (s3_data)
    );

    assign red   = s3_data.red;
    assign green = s3_data.green;
    assign blue  = s3_data.blue;

`ifndef SYNTHESIS
    // Back pressure only ever comes from the output side
    a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall)
        else $error("input stalled while output is free");

    // With no output stall an accepted item leaves after three stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("item lost in pipeline");

    // A new output item must come from stage 2
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s2_valid))
        else $error("output item appeared from nothing");
`endif

endmodule

### rtl/h2r_frac.sv
// Stage 1: hue sector, sector fraction and the saturation factors.
// Depends on h2r_pkg.
module h2r_frac (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  logic [7:0]        hue,
    input  logic [7:0]        saturation,
    input  logic [7:0]        brightness,
    output logic              dn_valid,
    input  logic              dn_stall,
    output h2r_pkg::h2r_frac_t dn_data
);
    import h2r_pkg::*;

    logic        valid_reg;
    h2r_frac_t   data_reg;
    h2r_frac_t   data_next;
    logic        advance;
    logic [10:0] six;
    logic [7:0]  f;
    logic [8:0]  f_comp;
    logic [15:0] sf;
    logic [16:0] sfc;

    assign advance = !valid_reg || !dn_stall;
    assign up_stall = !advance;

    always_comb
    begin
        six    = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        f      = six[7:0];
        f_comp = 9'd256 - {1'b0, f};
        sf     = 16'(saturation) * 16'(f);
        sfc    = 17'(saturation) * 17'(f_comp);
        data_next.sector = h2r_sector_t'(six[10:8]);
        data_next.v      = brightness;
        data_next.a_p    = 9'd256 - {1'b0, saturation};
        data_next.a_q    = 17'h10000 - {1'b0, sf};
        data_next.a_t    = 17'h10000 - sfc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### rtl/h2r_mul.sv
// Stage 2: multiply the value by the p, q and t factors.
// Depends on h2r_pkg.
module h2r_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_stall,
    input  h2r_pkg::h2r_frac_t up_data,
    output logic               dn_valid,
    input  logic               dn_stall,
    output h2r_pkg::h2r_prod_t dn_data
);
    import h2r_pkg::*;

    logic      valid_reg;
    h2r_prod_t data_reg;
    h2r_prod_t data_next;
    logic      advance;

    assign advance = !valid_reg || !dn_stall;
    assign up_stall = !advance;

    always_comb
    begin
        data_next.sector = up_data.sector;
        data_next.v      = up_data.v;
        data_next.p_num  = 17'(up_data.v) * 17'(up_data.a_p);
        data_next.q_num  = 25'(up_data.v) * 25'(up_data.a_q);
        data_next.t_num  = 25'(up_data.v) * 25'(up_data.a_t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### rtl/h2r_out.sv
// Stage 3: scale each fraction by 255, floor, and route by sector.
// Depends on h2r_pkg.
module h2r_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_stall,
    input  h2r_pkg::h2r_prod_t up_data,
    output logic               dn_valid,
    input  logic               dn_stall,
    output h2r_pkg::h2r_rgb_t  dn_data
);
    import h2r_pkg::*;

    logic        valid_reg;
    h2r_rgb_t    data_reg;
    h2r_rgb_t    data_next;
    logic        advance;
    logic [15:0] vw;
    logic [24:0] pw;
    logic [32:0] qw;
    logic [32:0] tw;
    logic [7:0]  vo;
    logic [7:0]  po;
    logic [7:0]  qo;
    logic [7:0]  to;

    assign advance = !valid_reg || !dn_stall;
    assign up_stall = !advance;

    // x*255 as (x << 8) - x
    always_comb
    begin
        vw = {up_data.v, 8'b0} - {8'b0, up_data.v};
        pw = {up_data.p_num, 8'b0} - {8'b0, up_data.p_num};
        qw = {up_data.q_num, 8'b0} - {8'b0, up_data.q_num};
        tw = {up_data.t_num, 8'b0} - {8'b0, up_data.t_num};
        vo = vw[15:8];
        po = pw[23:16];
        qo = qw[31:24];
        to = tw[31:24];
        case (up_data.sector)
            SEC_RED_YEL: data_next = '{red: vo, green: to, blue: po};
            SEC_YEL_GRN: data_next = '{red: qo, green: vo, blue: po};
            SEC_GRN_CYA: data_next = '{red: po, green: vo, blue: to};
            SEC_CYA_BLU: data_next = '{red: po, green: qo, blue: vo};
            SEC_BLU_MAG: data_next = '{red: to, green: po, blue: vo};
            default:     data_next = '{red: vo, green: po, blue: qo};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule
